### rtl/eiu_pkg.sv
// ----------------------------------------------------------------------------
// eiu_pkg
// Shared types and constants for the Ethernet / IPv4 / UDP header parser.
// ----------------------------------------------------------------------------
package eiu_pkg;

  // Frame layout
  localparam logic [16:0] OFF_ETYPE_HI  = 17'd12;
  localparam logic [16:0] OFF_ETYPE_LO  = 17'd13;
  localparam logic [16:0] OFF_VER_IHL   = 17'd14;
  localparam logic [16:0] OFF_PROTO     = 17'd23;
  localparam logic [16:0] OFF_SRC_FIRST = 17'd26;
  localparam logic [16:0] OFF_SRC_LAST  = 17'd29;
  localparam logic [16:0] OFF_DST_FIRST = 17'd30;
  localparam logic [16:0] OFF_DST_LAST  = 17'd33;
  localparam logic [16:0] OFFSET_MAX    = 17'h1FFFF;

  localparam logic [6:0]  ETH_HDR_LEN   = 7'd14;
  localparam logic [15:0] UDP_HDR_LEN   = 16'd8;
  localparam logic [17:0] MIN_FRAME_LEN = 18'd42;

  // Header field codes
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [7:0]  VERSION_MASK  = 8'hF0;
  localparam logic [7:0]  VERSION_IPV4  = 8'h40;

  // Header fields as they stand after the current byte is merged in
  typedef struct packed {
    logic [16:0] offset;
    logic [15:0] ether_kind;
    logic [7:0]  ver_ihl;
    logic [7:0]  ip_proto;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] udp_len;
    logic [6:0]  udp_start;
    logic [63:0] frame_time;
  } hdr_t;

  // One result item
  typedef struct packed {
    logic        frame_ok;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [6:0]  payload_offset;
    logic [15:0] payload_length;
    logic [63:0] frame_time;
  } res_t;

endpackage

### rtl/eth_ipv4_udp_header_parser.sv
// ----------------------------------------------------------------------------
// eth_ipv4_udp_header_parser
// Streaming Ethernet / IPv4 / UDP header parser, one frame byte per item.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per clock cycle and gives one result item
// per frame, on the byte marked last. A byte goes into an input register and
// from there is merged into the header capture registers; on the last byte
// the checked result lands in the output register and raises out_valid.
// in_stall is raised only while a last byte waits for an output register
// that is full and stalled; with the result side ready the rate is one byte
// every cycle. VLAN tags are not recognized; a frame that is too short, is
// not IPv4 UDP, whose UDP length is below the UDP header size, or whose UDP
// header or payload runs past the frame end is reported with out_frame_ok
// low and all fields zero except the first-byte timestamp.
module eth_ipv4_udp_header_parser (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [63:0] in_arrival_time,

  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_frame_ok,
  output logic [31:0] out_source_ip,
  output logic [31:0] out_dest_ip,
  output logic [15:0] out_source_port,
  output logic [15:0] out_dest_port,
  output logic [6:0]  out_payload_offset,
  output logic [15:0] out_payload_length,
  output logic [63:0] out_frame_time
);

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [63:0] s1_time_r;

  logic          out_valid_r;
  eiu_pkg::res_t out_res_r;

  logic          out_free;
  logic          s1_go;
  eiu_pkg::hdr_t hdr;
  eiu_pkg::res_t res;

  // A last byte may only proceed when the output register can take a result
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_last_byte;
      s1_time_r <= in_arrival_time;
    end
  end

  eiu_capture u_capture (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_en      (s1_go),
    .data_byte    (s1_byte_r),
    .last_byte    (s1_last_r),
    .arrival_time (s1_time_r),
    .hdr          (hdr)
  );

  eiu_check u_check (
    .hdr (hdr),
    .res (res)
  );

  // Output register: load on a processed last byte, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_ok       = out_res_r.frame_ok;
  assign out_source_ip      = out_res_r.source_ip;
  assign out_dest_ip        = out_res_r.dest_ip;
  assign out_source_port    = out_res_r.source_port;
  assign out_dest_port      = out_res_r.dest_port;
  assign out_payload_offset = out_res_r.payload_offset;
  assign out_payload_length = out_res_r.payload_length;
  assign out_frame_time     = out_res_r.frame_time;

`ifndef SYNTHESIS
  // Input backs up only behind a last byte blocked by a full, stalled output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked last byte");

  // A valid frame's payload offset lies between the smallest and largest UDP start plus the UDP header
  a_ok_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.frame_ok) |->
      (out_res_r.payload_offset >= 7'd22 && out_res_r.payload_offset <= 7'd82))
    else $error("payload offset out of range on a valid frame");

  // An invalid frame reports zero addresses, payload offset and payload length
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.frame_ok) |->
      (out_res_r.source_ip == 32'd0 && out_res_r.dest_ip == 32'd0 &&
       out_res_r.payload_offset == 7'd0 && out_res_r.payload_length == 16'd0))
    else $error("invalid frame carries nonzero fields");
`endif

endmodule

### rtl/eiu_capture.sv
// ----------------------------------------------------------------------------
// eiu_capture
// Byte offset counter and header field capture registers. Merges the current
// byte into the captured fields and clears everything after the last byte.
// ----------------------------------------------------------------------------
module eiu_capture (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  input  logic [63:0]         arrival_time,
  output eiu_pkg::hdr_t       hdr
);

  logic [16:0] offset_r;
  logic [15:0] ether_kind_r;
  logic [7:0]  ver_ihl_r;
  logic [7:0]  ip_proto_r;
  logic [31:0] src_ip_r;
  logic [31:0] dst_ip_r;
  logic [15:0] sport_r;
  logic [15:0] dport_r;
  logic [15:0] udp_len_r;
  logic [63:0] frame_time_r;

  logic [16:0] udp_rel;
  logic        in_udp_hdr;

  // Merge the current byte into the captured header
  always_comb begin
    hdr            = '0;
    hdr.offset     = offset_r;
    hdr.ether_kind = ether_kind_r;
    hdr.ver_ihl    = ver_ihl_r;
    hdr.ip_proto   = ip_proto_r;
    hdr.src_ip     = src_ip_r;
    hdr.dst_ip     = dst_ip_r;
    hdr.sport      = sport_r;
    hdr.dport      = dport_r;
    hdr.udp_len    = udp_len_r;
    hdr.frame_time = frame_time_r;

    if (offset_r == 17'd0) begin
      hdr.frame_time = arrival_time;
    end
    if (offset_r == eiu_pkg::OFF_ETYPE_HI || offset_r == eiu_pkg::OFF_ETYPE_LO) begin
      hdr.ether_kind = {ether_kind_r[7:0], data_byte};
    end
    if (offset_r == eiu_pkg::OFF_VER_IHL) begin
      hdr.ver_ihl = data_byte;
    end
    if (offset_r == eiu_pkg::OFF_PROTO) begin
      hdr.ip_proto = data_byte;
    end
    if (offset_r >= eiu_pkg::OFF_SRC_FIRST && offset_r <= eiu_pkg::OFF_SRC_LAST) begin
      hdr.src_ip = {src_ip_r[23:0], data_byte};
    end
    if (offset_r >= eiu_pkg::OFF_DST_FIRST && offset_r <= eiu_pkg::OFF_DST_LAST) begin
      hdr.dst_ip = {dst_ip_r[23:0], data_byte};
    end

    // UDP header begins after the IPv4 header (IHL in 32-bit words)
    hdr.udp_start = eiu_pkg::ETH_HDR_LEN + {1'b0, hdr.ver_ihl[3:0], 2'b00};
    udp_rel       = offset_r - {10'd0, hdr.udp_start};
    in_udp_hdr    = (offset_r >= {10'd0, hdr.udp_start}) && (udp_rel < 17'd6);

    if (in_udp_hdr) begin
      priority if (udp_rel[2:0] < 3'd2) begin
        hdr.sport = {sport_r[7:0], data_byte};
      end else if (udp_rel[2:0] < 3'd4) begin
        hdr.dport = {dport_r[7:0], data_byte};
      end else begin
        hdr.udp_len = {udp_len_r[7:0], data_byte};
      end
    end
  end

  // Hold the header; advance the offset, clear after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && last_byte)) begin
      offset_r     <= '0;
      ether_kind_r <= '0;
      ver_ihl_r    <= '0;
      ip_proto_r   <= '0;
      src_ip_r     <= '0;
      dst_ip_r     <= '0;
      sport_r      <= '0;
      dport_r      <= '0;
      udp_len_r    <= '0;
      frame_time_r <= '0;
    end else if (byte_en) begin
      if (offset_r != eiu_pkg::OFFSET_MAX) begin
        offset_r <= offset_r + 17'd1;
      end
      ether_kind_r <= hdr.ether_kind;
      ver_ihl_r    <= hdr.ver_ihl;
      ip_proto_r   <= hdr.ip_proto;
      src_ip_r     <= hdr.src_ip;
      dst_ip_r     <= hdr.dst_ip;
      sport_r      <= hdr.sport;
      dport_r      <= hdr.dport;
      udp_len_r    <= hdr.udp_len;
      frame_time_r <= hdr.frame_time;
    end
  end

endmodule

### rtl/eiu_check.sv
// ----------------------------------------------------------------------------
// eiu_check
// Frame validity checks and result formation from the captured header at
// the last byte. Fields other than the timestamp read zero when invalid.
// ----------------------------------------------------------------------------
module eiu_check (
  input  eiu_pkg::hdr_t hdr,
  output eiu_pkg::res_t res
);

  logic [17:0] frame_len;
  logic [17:0] udp_hdr_end;
  logic [17:0] udp_end;
  logic        ok;

  // Check length, EtherType, version, protocol and UDP bounds
  always_comb begin
    frame_len   = {1'b0, hdr.offset} + 18'd1;
    udp_hdr_end = {11'd0, hdr.udp_start} + 18'(eiu_pkg::UDP_HDR_LEN);
    udp_end     = {11'd0, hdr.udp_start} + {2'b00, hdr.udp_len};

    ok = (frame_len >= eiu_pkg::MIN_FRAME_LEN)
      && (hdr.ether_kind == eiu_pkg::ETYPE_IPV4)
      && ((hdr.ver_ihl & eiu_pkg::VERSION_MASK) == eiu_pkg::VERSION_IPV4)
      && (hdr.ip_proto == eiu_pkg::PROTO_UDP)
      && (udp_hdr_end <= frame_len)
      && (hdr.udp_len >= eiu_pkg::UDP_HDR_LEN)
      && (udp_end <= frame_len);

    res            = '0;
    res.frame_time = hdr.frame_time;
    if (ok) begin
      res.frame_ok       = 1'b1;
      res.source_ip      = hdr.src_ip;
      res.dest_ip        = hdr.dst_ip;
      res.source_port    = hdr.sport;
      res.dest_port      = hdr.dport;
      res.payload_offset = hdr.udp_start + 7'(eiu_pkg::UDP_HDR_LEN);
      res.payload_length = hdr.udp_len - eiu_pkg::UDP_HDR_LEN;
    end
  end

endmodule

### tb/tb_eth_ipv4_udp_header_parser.sv
// ----------------------------------------------------------------------------
// tb_eth_ipv4_udp_header_parser
// Self-checking bench for the Ethernet / IPv4 / UDP header parser. Frames
// are built byte by byte from a directed table, then from random well-formed
// and corrupted headers. Each accepted byte goes through a behavioral parser
// that predicts the summary unless a directed row types it in; each summary
// is checked field by field. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
module tb_eth_ipv4_udp_header_parser;
  timeunit 1ns;
  timeprecision 1ps;

  // One frame description; the expectation is typed in only where marked
  typedef struct packed {
    logic [31:0] len;
    logic [15:0] etype;
    logic [7:0]  ver_ihl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ulen;
    logic [63:0] stamp;
    logic        typed;
    logic        exp_ok;
    logic [6:0]  exp_off;
    logic [15:0] exp_plen;
  } frame_row_t;

  localparam int NUM_DIRECTED = 24;
  localparam int PHASE_BYTES  = 135;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic [63:0] in_arrival_time = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_frame_ok;
  logic [31:0] out_source_ip;
  logic [31:0] out_dest_ip;
  logic [15:0] out_source_port;
  logic [15:0] out_dest_port;
  logic [6:0]  out_payload_offset;
  logic [15:0] out_payload_length;
  logic [63:0] out_frame_time;

  // Behavioral parser state
  logic [16:0] st_offset = '0;
  logic [15:0] st_etype = '0;
  logic [7:0]  st_ver_ihl = '0;
  logic [7:0]  st_proto = '0;
  logic [31:0] st_src = '0;
  logic [31:0] st_dst = '0;
  logic [15:0] st_sport = '0;
  logic [15:0] st_dport = '0;
  logic [15:0] st_ulen = '0;
  logic [63:0] st_time = '0;

  eiu_pkg::res_t parsed_frames [$];
  logic [7:0]  frame_bytes [$];
  int          mismatch_count = 0;
  int          sender_idle_pct = 0;
  int          stall_pct = 0;
  int          idle_mix [4] = '{0, 60, 0, 19};
  int          stall_mix [4] = '{0, 0, 60, 19};

  // len, etype, ver_ihl, proto, src, dst, sport, dport, ulen, stamp,
  // typed, ok, payload offset, payload length
  frame_row_t directed_rows [NUM_DIRECTED] = '{
    // shortest valid frame, then all-ones and all-zero header fields
    '{32'd42, 16'h0800, 8'h45, 8'd17, 32'hC0A8_0001, 32'hC0A8_0002, 16'h1234,
      16'h5678, 16'd8, 64'd0, 1'b1, 1'b1, 7'd42, 16'd0},
    '{32'd60, 16'h0800, 8'h45, 8'd17, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
      16'hFFFF, 16'd26, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 7'd42, 16'd18},
    '{32'd42, 16'h0800, 8'h45, 8'd17, 32'h0, 32'h0, 16'h0, 16'h0, 16'd8,
      64'd1, 1'b1, 1'b1, 7'd42, 16'd0},
    // one byte short of the minimum
    '{32'd41, 16'h0800, 8'h45, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd53,
      16'd53, 16'd8, 64'h55, 1'b1, 1'b0, 7'd0, 16'd0},
    // wrong EtherType, including swapped bytes
    '{32'd42, 16'h86DD, 8'h45, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd8, 64'h66, 1'b1, 1'b0, 7'd0, 16'd0},
    '{32'd42, 16'h0801, 8'h45, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd8, 64'h67, 1'b1, 1'b0, 7'd0, 16'd0},
    '{32'd42, 16'h0008, 8'h45, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd8, 64'h68, 1'b1, 1'b0, 7'd0, 16'd0},
    // wrong IP version
    '{32'd42, 16'h0800, 8'h65, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd8, 64'h69, 1'b1, 1'b0, 7'd0, 16'd0},
    '{32'd42, 16'h0800, 8'h55, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd8, 64'h6A, 1'b1, 1'b0, 7'd0, 16'd0},
    // wrong protocol
    '{32'd42, 16'h0800, 8'h45, 8'd6, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd8, 64'h6B, 1'b1, 1'b0, 7'd0, 16'd0},
    '{32'd42, 16'h0800, 8'h45, 8'h91, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd8, 64'h6C, 1'b1, 1'b0, 7'd0, 16'd0},
    // UDP length below the header size
    '{32'd42, 16'h0800, 8'h45, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd7, 64'h6D, 1'b1, 1'b0, 7'd0, 16'd0},
    '{32'd42, 16'h0800, 8'h45, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd0, 64'h6E, 1'b1, 1'b0, 7'd0, 16'd0},
    // payload one past the frame end, then exactly at it
    '{32'd50, 16'h0800, 8'h45, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd17, 64'h6F, 1'b1, 1'b0, 7'd0, 16'd0},
    '{32'd50, 16'h0800, 8'h45, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd16, 64'h70, 1'b1, 1'b1, 7'd42, 16'd8},
    // largest IHL, its UDP header past the frame end, then a huge UDP length
    '{32'd90, 16'h0800, 8'h4F, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd16, 64'h71, 1'b1, 1'b1, 7'd82, 16'd8},
    '{32'd80, 16'h0800, 8'h4F, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'd8, 64'h72, 1'b1, 1'b0, 7'd0, 16'd0},
    '{32'd64, 16'h0800, 8'h45, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'd1,
      16'd2, 16'hFFFF, 64'h73, 1'b1, 1'b0, 7'd0, 16'd0},
    // small IHL: UDP header laid over the IPv4 header
    '{32'd60, 16'h0800, 8'h40, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'h4000,
      16'h0035, 16'd8, 64'h74, 1'b0, 1'b0, 7'd0, 16'd0},
    '{32'd60, 16'h0800, 8'h42, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'h0011,
      16'h0035, 16'd8, 64'h75, 1'b0, 1'b0, 7'd0, 16'd0},
    '{32'd60, 16'h0800, 8'h44, 8'd17, 32'h0A00_0001, 32'h0A00_0002, 16'h1000,
      16'h2000, 16'd8, 64'h76, 1'b0, 1'b0, 7'd0, 16'd0},
    // one- and two-byte frames
    '{32'd1, 16'h0800, 8'h45, 8'd17, 32'h0, 32'h0, 16'h0, 16'h0, 16'd8,
      64'h0123_4567_89AB_CDEF, 1'b1, 1'b0, 7'd0, 16'd0},
    '{32'd2, 16'h0800, 8'h45, 8'd17, 32'h0, 32'h0, 16'h0, 16'h0, 16'd8,
      64'hFEDC_BA98_7654_3210, 1'b1, 1'b0, 7'd0, 16'd0},
    // ordinary frame with options
    '{32'd100, 16'h0800, 8'h46, 8'd17, 32'hAC10_0203, 32'hE000_00FB, 16'd5353,
      16'd5353, 16'd40, 64'h1234_5678, 1'b0, 1'b0, 7'd0, 16'd0}
  };

  eth_ipv4_udp_header_parser uut (.*);

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the parser model by one byte; return 1 when the byte ends a frame
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    input logic [63:0] t, output eiu_pkg::res_t r);
    int unsigned off, vi, ustart, flen, rel;
    bit ok;
    off = {15'd0, st_offset};
    r = '0;
    if (off == 0) st_time = t;
    if (off == eiu_pkg::OFF_ETYPE_HI || off == eiu_pkg::OFF_ETYPE_LO)
      st_etype = {st_etype[7:0], b};
    if (off == eiu_pkg::OFF_VER_IHL) st_ver_ihl = b;
    if (off == eiu_pkg::OFF_PROTO) st_proto = b;
    if (off >= eiu_pkg::OFF_SRC_FIRST && off <= eiu_pkg::OFF_SRC_LAST)
      st_src = {st_src[23:0], b};
    if (off >= eiu_pkg::OFF_DST_FIRST && off <= eiu_pkg::OFF_DST_LAST)
      st_dst = {st_dst[23:0], b};

    // UDP header position follows the IHL, including the byte carrying it
    vi = (off == eiu_pkg::OFF_VER_IHL) ? {24'd0, b} : {24'd0, st_ver_ihl};
    ustart = eiu_pkg::ETH_HDR_LEN + (vi & 32'hF) * 4;
    if (off >= eiu_pkg::OFF_VER_IHL && off >= ustart && off - ustart < 6) begin
      rel = off - ustart;
      if (rel < 2) st_sport = {st_sport[7:0], b};
      else if (rel < 4) st_dport = {st_dport[7:0], b};
      else st_ulen = {st_ulen[7:0], b};
    end

    if (!last) begin
      if (st_offset != eiu_pkg::OFFSET_MAX) st_offset = st_offset + 17'd1;
      return 1'b0;
    end

    flen = off + 1;
    ok = flen >= eiu_pkg::MIN_FRAME_LEN && st_etype == eiu_pkg::ETYPE_IPV4
      && (st_ver_ihl & eiu_pkg::VERSION_MASK) == eiu_pkg::VERSION_IPV4
      && st_proto == eiu_pkg::PROTO_UDP
      && ustart + eiu_pkg::UDP_HDR_LEN <= flen && st_ulen >= eiu_pkg::UDP_HDR_LEN
      && ustart + st_ulen <= flen;
    r.frame_ok       = ok;
    r.source_ip      = ok ? st_src : '0;
    r.dest_ip        = ok ? st_dst : '0;
    r.source_port    = ok ? st_sport : '0;
    r.dest_port      = ok ? st_dport : '0;
    r.payload_offset = ok ? 7'(ustart + eiu_pkg::UDP_HDR_LEN) : '0;
    r.payload_length = ok ? st_ulen - eiu_pkg::UDP_HDR_LEN : '0;
    r.frame_time     = st_time;

    // Clear for the next frame
    st_offset = '0;
    st_etype = '0;
    st_ver_ihl = '0;
    st_proto = '0;
    st_src = '0;
    st_dst = '0;
    st_sport = '0;
    st_dport = '0;
    st_ulen = '0;
    st_time = '0;
    return 1'b1;
  endfunction

  function automatic void place(int unsigned idx, logic [7:0] v);
    if (idx < frame_bytes.size()) frame_bytes[idx] = v;
  endfunction

  // Lay out a frame: random filler, IPv4 fields, then the UDP header on top
  function automatic void build_frame(input frame_row_t row);
    int unsigned ustart;
    frame_bytes.delete();
    for (int unsigned i = 0; i < row.len; i++) frame_bytes.push_back(8'($urandom));
    ustart = eiu_pkg::ETH_HDR_LEN + row.ver_ihl[3:0] * 4;
    place(12, row.etype[15:8]);
    place(13, row.etype[7:0]);
    place(14, row.ver_ihl);
    place(23, row.proto);
    for (int k = 0; k < 4; k++) begin
      place(26 + k, row.src[31 - 8 * k -: 8]);
      place(30 + k, row.dst[31 - 8 * k -: 8]);
    end
    place(ustart,     row.sport[15:8]);
    place(ustart + 1, row.sport[7:0]);
    place(ustart + 2, row.dport[15:8]);
    place(ustart + 3, row.dport[7:0]);
    place(ustart + 4, row.ulen[15:8]);
    place(ustart + 5, row.ulen[7:0]);
  endfunction

  // Well-formed UDP frame with random content; corrupt about a third
  function automatic frame_row_t random_row();
    frame_row_t row;
    int unsigned ihl, ustart;
    row = '0;
    ihl = $urandom_range(5, 15);
    ustart = eiu_pkg::ETH_HDR_LEN + ihl * 4;
    row.etype   = eiu_pkg::ETYPE_IPV4;
    row.ver_ihl = eiu_pkg::VERSION_IPV4 | 8'(ihl);
    row.proto   = eiu_pkg::PROTO_UDP;
    row.src     = $urandom;
    row.dst     = $urandom;
    row.sport   = 16'($urandom);
    row.dport   = 16'($urandom);
    row.ulen    = 16'($urandom_range(8, 24));
    row.len     = ustart + row.ulen + $urandom_range(0, 6);
    row.stamp   = {$urandom, $urandom};
    if ($urandom_range(0, 99) >= 70) begin
      case ($urandom_range(0, 8))
        0: row.etype = 16'($urandom);
        1: row.ver_ihl[7:4] = 4'($urandom);
        2: row.proto = 8'($urandom);
        3: row.ulen = 16'($urandom_range(0, 7));
        4: row.ulen = 16'(row.len - ustart + $urandom_range(1, 3));
        5: row.len = $urandom_range(1, ustart + 7);
        6: row.ver_ihl[3:0] = 4'($urandom_range(0, 4));
        7: begin
          row.etype = 16'($urandom);
          row.ver_ihl = 8'($urandom);
          row.proto = 8'($urandom);
        end
        default: row.len = $urandom_range(1, 45);
      endcase
    end
    return row;
  endfunction

  // Offer one byte, hold it until accepted, and predict at acceptance
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [63:0] t,
                           input bit use_typed, input eiu_pkg::res_t typed_res);
    eiu_pkg::res_t r;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data_byte    <= b;
    in_last_byte    <= last;
    in_arrival_time <= t;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    if (parse_byte(b, last, t, r)) parsed_frames.push_back(use_typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_row_t row);
    eiu_pkg::res_t typed_res;
    int unsigned n;
    typed_res.frame_ok       = row.exp_ok;
    typed_res.source_ip      = row.exp_ok ? row.src : '0;
    typed_res.dest_ip        = row.exp_ok ? row.dst : '0;
    typed_res.source_port    = row.exp_ok ? row.sport : '0;
    typed_res.dest_port      = row.exp_ok ? row.dport : '0;
    typed_res.payload_offset = row.exp_off;
    typed_res.payload_length = row.exp_plen;
    typed_res.frame_time     = row.stamp;
    build_frame(row);
    n = frame_bytes.size();
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(frame_bytes[i], i == n - 1, (i == 0) ? row.stamp : {$urandom, $urandom},
                row.typed, typed_res);
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      if (mismatch_count < 10) $display("mismatch on %s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver stalls
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each accepted summary with the oldest prediction
  always @(posedge clk) begin : check_results
    eiu_pkg::res_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (parsed_frames.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result item at %0t", $realtime);
        mismatch_count++;
      end else begin
        want = parsed_frames.pop_front();
        check_field("frame_ok", want.frame_ok, out_frame_ok);
        check_field("source_ip", want.source_ip, out_source_ip);
        check_field("dest_ip", want.dest_ip, out_dest_ip);
        check_field("source_port", want.source_port, out_source_port);
        check_field("dest_port", want.dest_port, out_dest_port);
        check_field("payload_offset", want.payload_offset, out_payload_offset);
        check_field("payload_length", want.payload_length, out_payload_length);
        check_field("frame_time", want.frame_time, out_frame_time);
      end
    end
  end

  // Main sequence
  initial begin
    int sent;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames with no gaps
    for (int i = 0; i < NUM_DIRECTED; i++) send_frame(directed_rows[i]);

    // Random frames under each gap and stall mix
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct = idle_mix[p];
      stall_pct = stall_mix[p];
      sent = 0;
      while (sent < PHASE_BYTES) begin
        frame_row_t row;
        row = random_row();
        send_frame(row);
        sent += row.len;
      end
    end
    in_valid <= 1'b0;

    // Drain
    for (int n = 0; n < 5000 && parsed_frames.size() != 0; n++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && parsed_frames.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

### eth_ipv4_udp_header_parser.f
rtl/eiu_pkg.sv
rtl/eiu_capture.sv
rtl/eiu_check.sv
rtl/eth_ipv4_udp_header_parser.sv
tb/tb_eth_ipv4_udp_header_parser.sv
